### rtl/sfl_pkg.sv
// shared types and constants for the stereo fir low-pass block
// no dependencies; used by stereo_fir_lowpass
package sfl_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int COEF_W             = 16;
  localparam int IDX_W              = 8;
  localparam int TAPS_W             = 9;
  localparam int IN_DATA_W          = 64;
  localparam int OUT_DATA_W         = 32;
  localparam int PROD_W             = SAMPLE_W + COEF_W;

  localparam int DEF_MAX_TAPS       = 256;
  localparam int DEF_COEF_FRAC_BITS = 15;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 9'd201;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } sfl_state_t;

endpackage

### rtl/sfl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/stereo_fir_lowpass.sv
// stereo direct-form fir filter, one coefficient set shared by both channels
// depends on sfl_pkg and sfl_ram
// usage:
//   in_* carries items. tuser = 0 is a stereo sample pair, tuser = 1 writes one
//   coefficient into the coefficient store (index beyond the store is ignored).
//   a sample item gives one result on out_*: both filtered channels and a
//   clipped flag; a coefficient item gives none.
//   cfg_* writes taps_in_use (taps beyond MAX_TAPS are clamped); write it only
//   while the block is idle.
// timing:
//   a coefficient item is written while the block stays idle. a sample item
//   walks the taps through one multiply-accumulate lane per channel, one tap
//   per cycle, via ram read, product register and accumulator; the result is
//   then registered on out_*, and out_tvalid rises in the same cycle that
//   in_tready returns. zero taps skips the walk and gives a zero result.
// reset and stall:
//   reset clears the sample history (by a fill count), the newest position and
//   sets taps_in_use to 201. coefficients are undefined until written.
//   a waiting result does not block the next item; the block only holds its
//   next result until out_tready takes the previous one.
module stereo_fir_lowpass #(
  parameter int MAX_TAPS       = sfl_pkg::DEF_MAX_TAPS,
  parameter int COEF_FRAC_BITS = sfl_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // left_sample, right_sample, restart, coef_index, coef_value, zero pad
  input  logic [sfl_pkg::IN_DATA_W-1:0]    in_tdata,
  // req_type
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // left_out, right_out
  output logic [sfl_pkg::OUT_DATA_W-1:0]   out_tdata,
  // clipped
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfl_pkg::TAPS_W-1:0]       cfg_data
);

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int FW     = $clog2(MAX_TAPS + 1);
  localparam int TW     = (FW > sfl_pkg::TAPS_W) ? FW : sfl_pkg::TAPS_W;
  localparam int XW     = ((AW > sfl_pkg::IDX_W) ? AW : sfl_pkg::IDX_W) + 1;
  localparam int PW     = sfl_pkg::PROD_W;
  localparam int ACC_W  = PW + TW;
  localparam int SW     = sfl_pkg::SAMPLE_W;

  localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(sfl_pkg::SAT_MAX);
  localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(sfl_pkg::SAT_MIN);
  localparam logic [AW-1:0] POS_LAST = AW'(MAX_TAPS - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(MAX_TAPS);
  localparam logic [TW-1:0] TAPS_MAX = TW'(MAX_TAPS);

  // input fields
  logic signed [SW-1:0]             in_left;
  logic signed [SW-1:0]             in_right;
  logic                             in_restart;
  logic [sfl_pkg::IDX_W-1:0]        in_cidx;
  logic [sfl_pkg::COEF_W-1:0]       in_cval;

  assign in_left    = in_tdata[15:0];
  assign in_right   = in_tdata[31:16];
  assign in_restart = in_tdata[32];
  assign in_cidx    = in_tdata[40:33];
  assign in_cval    = in_tdata[56:41];

  // control state
  sfl_pkg::sfl_state_t state_r, state_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic [FW-1:0]               fill_r, fill_nxt;
  logic [sfl_pkg::TAPS_W-1:0]  taps_r, taps_nxt;
  logic [TW-1:0]               tap_idx_r, tap_idx_nxt;
  logic [TW-1:0]               taps_run_r, taps_run_nxt;
  logic [AW-1:0]               slot_r, slot_nxt;
  logic                        v1_r, v1_nxt;
  logic                        v2_r, v2_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // datapath
  logic                        z1_r, z1_nxt;
  logic signed [PW-1:0]        prod_l_r, prod_l_nxt;
  logic signed [PW-1:0]        prod_r_r, prod_r_nxt;
  logic signed [ACC_W-1:0]     acc_l_r, acc_l_nxt;
  logic signed [ACC_W-1:0]     acc_r_r, acc_r_nxt;
  logic [SW-1:0]               out_l_r, out_l_nxt;
  logic [SW-1:0]               out_r_r, out_r_nxt;
  logic                        out_clip_r, out_clip_nxt;

  // ram ports
  logic                        hist_we;
  logic [2*SW-1:0]             hist_wdata;
  logic [2*SW-1:0]             hist_rdata;
  logic                        coef_we;
  logic [AW-1:0]               coef_waddr;
  logic [sfl_pkg::COEF_W-1:0]  coef_rdata;
  logic                        rd_en;

  logic                        in_acc;
  logic [XW-1:0]               cidx_ext;
  logic [TW-1:0]               taps_eff;
  logic [AW-1:0]               pos_adv;
  logic [FW-1:0]               fill_adv;
  logic signed [SW-1:0]        q_l, q_r;
  logic                        clip_l, clip_r;
  logic                        out_load;

  sfl_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (pos_nxt),
    .wdata (hist_wdata),
    .re    (rd_en),
    .raddr (slot_r),
    .rdata (hist_rdata)
  );

  sfl_ram #(
    .WIDTH (sfl_pkg::COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_cval),
    .re    (rd_en),
    .raddr (tap_idx_r[AW-1:0]),
    .rdata (coef_rdata)
  );

  // truncate toward zero, then saturate to the sample range
  function automatic logic [SW:0] trunc_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] q;
    logic [SW:0]             res;
    biased = acc + (acc[ACC_W-1] ? $signed(RND_BIAS) : $signed({ACC_W{1'b0}}));
    q      = biased >>> COEF_FRAC_BITS;
    if (q > Y_MAX) begin
      res = {1'b1, Y_MAX[SW-1:0]};
    end else if (q < Y_MIN) begin
      res = {1'b1, Y_MIN[SW-1:0]};
    end else begin
      res = {1'b0, q[SW-1:0]};
    end
    return res;
  endfunction

  assign in_tready  = (state_r == sfl_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r_r, out_l_r};
  assign out_tuser  = out_clip_r;

  assign cidx_ext   = XW'(in_cidx);
  assign coef_waddr = cidx_ext[AW-1:0];
  assign coef_we    = in_acc && (in_tuser == sfl_pkg::REQ_COEF) && (cidx_ext < XW'(MAX_TAPS));
  assign hist_we    = in_acc && (in_tuser == sfl_pkg::REQ_SAMPLE);
  assign hist_wdata = {in_right, in_left};
  assign rd_en      = (state_r == sfl_pkg::ST_MAC);

  assign taps_eff = (TW'(taps_r) > TAPS_MAX) ? TAPS_MAX : TW'(taps_r);
  assign pos_adv  = in_restart ? AW'(1) : ((pos_r == POS_LAST) ? '0 : pos_r + AW'(1));
  assign fill_adv = in_restart ? FW'(1) : ((fill_r == FILL_FULL) ? FILL_FULL : fill_r + FW'(1));

  assign {clip_l, q_l} = trunc_sat(acc_l_r);
  assign {clip_r, q_r} = trunc_sat(acc_r_r);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    taps_nxt      = taps_r;
    tap_idx_nxt   = tap_idx_r;
    taps_run_nxt  = taps_run_r;
    slot_nxt      = slot_r;
    v1_nxt        = 1'b0;
    v2_nxt        = v1_r;
    z1_nxt        = z1_r;
    out_valid_nxt = out_valid_r;
    acc_l_nxt     = acc_l_r;
    acc_r_nxt     = acc_r_r;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    out_clip_nxt  = out_clip_r;
    out_load      = 1'b0;

    if (cfg_valid && cfg_ready) begin
      taps_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // multiply stage
    prod_l_nxt = '0;
    prod_r_nxt = '0;
    if (v1_r && !z1_r) begin
      prod_l_nxt = $signed(coef_rdata) * $signed(hist_rdata[SW-1:0]);
      prod_r_nxt = $signed(coef_rdata) * $signed(hist_rdata[2*SW-1:SW]);
    end

    // accumulate stage
    if (v2_r) begin
      acc_l_nxt = acc_l_r + {{(ACC_W-PW){prod_l_r[PW-1]}}, prod_l_r};
      acc_r_nxt = acc_r_r + {{(ACC_W-PW){prod_r_r[PW-1]}}, prod_r_r};
    end

    unique case (state_r)
      sfl_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == sfl_pkg::REQ_SAMPLE)) begin
          pos_nxt      = pos_adv;
          fill_nxt     = fill_adv;
          slot_nxt     = pos_adv;
          tap_idx_nxt  = '0;
          taps_run_nxt = taps_eff;
          acc_l_nxt    = '0;
          acc_r_nxt    = '0;
          state_nxt    = (taps_eff == '0) ? sfl_pkg::ST_DRAIN : sfl_pkg::ST_MAC;
        end
      end
      sfl_pkg::ST_MAC: begin
        v1_nxt      = 1'b1;
        z1_nxt      = (tap_idx_r >= TW'(fill_r));
        tap_idx_nxt = tap_idx_r + TW'(1);
        slot_nxt    = (slot_r == '0) ? POS_LAST : slot_r - AW'(1);
        if (tap_idx_r == taps_run_r - TW'(1)) begin
          state_nxt = sfl_pkg::ST_DRAIN;
        end
      end
      sfl_pkg::ST_DRAIN: begin
        if (!v1_r && !v2_r && (!out_valid_r || out_tready)) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_l_nxt     = q_l;
          out_r_nxt     = q_r;
          out_clip_nxt  = clip_l || clip_r;
          state_nxt     = sfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfl_pkg::ST_IDLE;
      pos_r       <= '0;
      fill_r      <= '0;
      taps_r      <= sfl_pkg::TAPS_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      taps_r      <= taps_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tap_idx_r  <= tap_idx_nxt;
    taps_run_r <= taps_run_nxt;
    slot_r     <= slot_nxt;
    z1_r       <= z1_nxt;
    prod_l_r   <= prod_l_nxt;
    prod_r_r   <= prod_r_nxt;
    acc_l_r    <= acc_l_nxt;
    acc_r_r    <= acc_r_nxt;
    if (out_load) begin
      out_l_r    <= out_l_nxt;
      out_r_r    <= out_r_nxt;
      out_clip_r <= out_clip_nxt;
    end
  end

endmodule
